// ===== rtl/vod_pkg.sv =====
// shared types, constants and helper functions for the voxel occupancy dilation block
// no dependencies
`default_nettype none

package vod_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int START_W    = 6;
   localparam int END_W      = 7;

   localparam logic [CSR_IDX_W-1:0] REG_X_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_END   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Z_END   = 3'd5;

   localparam logic [START_W-1:0] BOX_START_RESET = 6'd0;
   localparam logic [END_W-1:0]   BOX_END_RESET   = 7'd64;

   // coordinate compare width, covers volume sizes up to 256
   localparam int CMP_W = 9;

   localparam int CELL_W     = 8;
   localparam int PASS_COUNT = 23;

   localparam logic [CELL_W-1:0] PASS_TYPES [PASS_COUNT] = '{
      8'd6,  8'd20, 8'd37, 8'd38, 8'd39, 8'd40, 8'd51, 8'd55,
      8'd59, 8'd63, 8'd64, 8'd65, 8'd66, 8'd68, 8'd69, 8'd71,
      8'd75, 8'd76, 8'd77, 8'd83, 8'd85, 8'd86, 8'd91
   };

   typedef struct packed {
      logic near_solid;
      logic flag_written;
      logic box_done;
   } rsp_item_type;

   function automatic logic is_occupied(input logic [CELL_W-1:0] t);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < PASS_COUNT; i++) begin
         if (t == PASS_TYPES[i]) hit = 1'b1;
      end
      return (t != '0) && !hit;
   endfunction

   function automatic logic [CMP_W-1:0] eff_start(input logic [START_W-1:0] s,
                                                  input logic [CMP_W-1:0]   size);
      logic [CMP_W-1:0] sw;
      sw = CMP_W'(s);
      return (sw >= size) ? size - 1'b1 : sw;
   endfunction

   function automatic logic [CMP_W-1:0] eff_end(input logic [START_W-1:0] s,
                                                input logic [END_W-1:0]   e,
                                                input logic [CMP_W-1:0]   size);
      logic [CMP_W-1:0] st;
      logic [CMP_W-1:0] en;
      st = eff_start(s, size);
      en = (CMP_W'(e) > size) ? size : CMP_W'(e);
      return (en <= st) ? st + 1'b1 : en;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vod_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module vod_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32768
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/voxel_occupancy_dilation.sv =====
// voxel occupancy dilation, top level
// uses vod_pkg and eight vod_ram banks holding the occupancy of the whole volume
//
// usage: cell types of the configured box arrive on req_* in raster order, x fastest,
// then y, then z. each item gives one result item on rsp_*: near_solid is the or of the
// occupancy of the voxel and its seven lower neighbours, gated by flag_written, which
// says all coordinates are at least 1; box_done marks the last voxel of the box.
// csr_* writes a box register; the user must write only while the block is idle,
// which the block does not enforce. any write restarts the position at the box start.
// throughput: one item per cycle while req_ready is high. the eight neighbours fall in
// eight parity banks, so each bank gets one read and the own bank one write per item.
// path: an accepted item passes the read stage register, then the result queue, to rsp_*.
// reset: a clearing pass writes zero to every bank entry, one entry per bank per
// cycle, over HX*HY*HZ entries per bank (32768 at the defaults, each axis halved and
// rounded up); req_ready stays low until it ends.
// stall: a three-entry result queue absorbs items in flight; req_ready drops once
// the queue and the read stage hold three items.
`default_nettype none

module voxel_occupancy_dilation
   import vod_pkg::*;
#(
   parameter int SIZE_X = 64,
   parameter int SIZE_Y = 64,
   parameter int SIZE_Z = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CELL_W-1:0]     req_cell_type,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_near_solid,
   output logic                       rsp_flag_written,
   output logic                       rsp_box_done,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW     = $clog2(SIZE_X);
   localparam int YW     = $clog2(SIZE_Y);
   localparam int ZW     = $clog2(SIZE_Z);
   localparam int HX     = (SIZE_X + 1) / 2;
   localparam int HY     = (SIZE_Y + 1) / 2;
   localparam int HZ     = (SIZE_Z + 1) / 2;
   localparam int HXY    = HX * HY;
   localparam int BANK_D = HX * HY * HZ;
   localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
   localparam int BANKS  = 8;
   localparam int QDEPTH = 3;

   // configuration registers
   logic [START_W-1:0] x_start_ff, y_start_ff, z_start_ff;
   logic [END_W-1:0]   x_end_ff, y_end_ff, z_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= BOX_START_RESET;
         y_start_ff <= BOX_START_RESET;
         z_start_ff <= BOX_START_RESET;
         x_end_ff   <= BOX_END_RESET;
         y_end_ff   <= BOX_END_RESET;
         z_end_ff   <= BOX_END_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_X_START: x_start_ff <= csr_wdata[START_W-1:0];
            REG_Y_START: y_start_ff <= csr_wdata[START_W-1:0];
            REG_Z_START: z_start_ff <= csr_wdata[START_W-1:0];
            REG_X_END:   x_end_ff   <= csr_wdata;
            REG_Y_END:   y_end_ff   <= csr_wdata;
            REG_Z_END:   z_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CMP_W-1:0] xs, ys, zs, xe, ye, ze;

   assign xs = eff_start(x_start_ff, CMP_W'(SIZE_X));
   assign ys = eff_start(y_start_ff, CMP_W'(SIZE_Y));
   assign zs = eff_start(z_start_ff, CMP_W'(SIZE_Z));
   assign xe = eff_end(x_start_ff, x_end_ff, CMP_W'(SIZE_X));
   assign ye = eff_end(y_start_ff, y_end_ff, CMP_W'(SIZE_Y));
   assign ze = eff_end(z_start_ff, z_end_ff, CMP_W'(SIZE_Z));

   // clearing pass after reset
   logic            clr_busy_ff;
   logic [BA_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == BA_W'(BANK_D - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // read stage and result queue state
   logic                     s1_valid_ff;
   logic                     s1_occ_ff;
   logic                     s1_flag_ff;
   logic                     s1_done_ff;
   logic [BANKS-1:0]         s1_own_ff;
   logic [1:0]               q_cnt_ff;
   logic [1:0]               q_wr_ptr_ff, q_rd_ptr_ff;
   rsp_item_type             q_ff [QDEPTH];
   logic [2:0]               in_flight;
   logic                     accept;

   assign in_flight = {1'b0, q_cnt_ff} + {2'b0, s1_valid_ff};
   assign req_ready = !clr_busy_ff && (in_flight < 3'(QDEPTH));
   assign accept    = req_valid && req_ready;

   // position
   logic          reload_ff;
   logic [XW-1:0] pos_x_ff, cur_x, nxt_x;
   logic [YW-1:0] pos_y_ff, cur_y, nxt_y;
   logic [ZW-1:0] pos_z_ff, cur_z, nxt_z;
   logic [CMP_W-1:0] xp1, yp1, zp1;
   logic          x_wrap, y_wrap, z_wrap;
   logic          cur_flag, cur_done, cur_occ;

   // a pending reload takes the box start straight away
   assign cur_x = reload_ff ? XW'(xs) : pos_x_ff;
   assign cur_y = reload_ff ? YW'(ys) : pos_y_ff;
   assign cur_z = reload_ff ? ZW'(zs) : pos_z_ff;

   assign xp1    = CMP_W'(cur_x) + 1'b1;
   assign yp1    = CMP_W'(cur_y) + 1'b1;
   assign zp1    = CMP_W'(cur_z) + 1'b1;
   assign x_wrap = xp1 >= xe;
   assign y_wrap = yp1 >= ye;
   assign z_wrap = zp1 >= ze;

   assign cur_done = x_wrap && y_wrap && z_wrap;
   assign cur_flag = (cur_x != '0) && (cur_y != '0) && (cur_z != '0);
   assign cur_occ  = is_occupied(req_cell_type);

   always_comb begin
      nxt_x = x_wrap ? XW'(xs) : XW'(xp1);
      nxt_y = cur_y;
      nxt_z = cur_z;
      if (x_wrap) begin
         nxt_y = y_wrap ? YW'(ys) : YW'(yp1);
         if (y_wrap) begin
            nxt_z = z_wrap ? ZW'(zs) : ZW'(zp1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= 1'b1;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
      end else if (csr_wen) begin
         reload_ff <= 1'b1;
      end else if (accept) begin
         reload_ff <= 1'b0;
         pos_x_ff  <= nxt_x;
         pos_y_ff  <= nxt_y;
         pos_z_ff  <= nxt_z;
      end
   end

   // half coordinates per parity: the bank of parity p holds x or x-1, whichever matches
   logic [BA_W-1:0] xh [2];
   logic [BA_W-1:0] yh [2];
   logic [BA_W-1:0] zh [2];

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         xh[p] = BA_W'((((cur_x[0] == p[0]) || (cur_x == '0)) ? cur_x : cur_x - 1'b1) >> 1);
         yh[p] = BA_W'((((cur_y[0] == p[0]) || (cur_y == '0)) ? cur_y : cur_y - 1'b1) >> 1);
         zh[p] = BA_W'((((cur_z[0] == p[0]) || (cur_z == '0)) ? cur_z : cur_z - 1'b1) >> 1);
      end
   end

   logic [2:0]       own_bank;
   logic [BANKS-1:0] own_onehot;
   logic [BANKS-1:0] bank_rd;

   assign own_bank   = {cur_z[0], cur_y[0], cur_x[0]};
   assign own_onehot = BANKS'(1) << own_bank;

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [BA_W-1:0] addr;
      logic            wr_en;
      logic [BA_W-1:0] wr_addr;

      assign addr    = xh[b % 2] + yh[(b / 2) % 2] * BA_W'(HX)
                       + zh[b / 4] * BA_W'(HXY);
      assign wr_en   = clr_busy_ff || (accept && own_onehot[b]);
      assign wr_addr = clr_busy_ff ? clr_addr_ff : addr;

      vod_ram #(
         .WIDTH (1),
         .DEPTH (BANK_D)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (!clr_busy_ff && cur_occ),
         .rd_en   (accept),
         .rd_addr (addr),
         .rd_data (bank_rd[b])
      );
   end

   // read stage: the own bank is written in the same cycle, so its read is replaced
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_occ_ff  <= cur_occ;
         s1_flag_ff <= cur_flag;
         s1_done_ff <= cur_done;
         s1_own_ff  <= own_onehot;
      end
   end

   rsp_item_type s1_item;

   assign s1_item.near_solid   = s1_flag_ff && (s1_occ_ff || |(bank_rd & ~s1_own_ff));
   assign s1_item.flag_written = s1_flag_ff;
   assign s1_item.box_done     = s1_done_ff;

   // result queue
   logic push, pop;

   assign push = s1_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff    <= '0;
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= (q_wr_ptr_ff == 2'(QDEPTH - 1)) ? '0 : q_wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            q_rd_ptr_ff <= (q_rd_ptr_ff == 2'(QDEPTH - 1)) ? '0 : q_rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            q_cnt_ff <= q_cnt_ff + 1'b1;
         end else if (pop && !push) begin
            q_cnt_ff <= q_cnt_ff - 1'b1;
         end
      end
      if (push) begin
         q_ff[q_wr_ptr_ff] <= s1_item;
      end
   end

   rsp_item_type q_head;

   assign q_head           = q_ff[q_rd_ptr_ff];
   assign rsp_valid        = q_cnt_ff != '0;
   assign rsp_near_solid   = q_head.near_solid;
   assign rsp_flag_written = q_head.flag_written;
   assign rsp_box_done     = q_head.box_done;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for voxel_occupancy_dilation: directed rows, then random box settings and cell streams
// holds its own occupancy map and raster cursor to predict each result item; depends on vod_pkg
`default_nettype none

module testbench;
   import vod_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SX = 64;
   localparam int SY = 64;
   localparam int SZ = 64;
   localparam int AXIS_SIZE [3] = '{SX, SY, SZ};
   localparam int VOLUME_CELLS = SX * SY * SZ;

   localparam int TARGET_CELLS  = 1800;
   localparam int SETTLE_CYCLES = 4;
   // limit on cycles with no item moving, above the clearing pass and the longest stalls
   localparam int STALL_LIMIT   = 100000;
   // whole run, well above the clearing pass plus every item under the longest gaps
   localparam int RUN_LIMIT     = 2000000;
   localparam int MAX_REPORTS   = 10;
   localparam int PEND_DEPTH    = 64;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;
   localparam logic [CSR_IDX_W-1:0] START_REG [3] = '{REG_X_START, REG_Y_START, REG_Z_START};
   localparam logic [CSR_IDX_W-1:0] END_REG [3]   = '{REG_X_END, REG_Y_END, REG_Z_END};

   typedef enum logic {ROW_CSR, ROW_CELL} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  value;
      logic [CELL_W-1:0]      voxel;
      logic                   typed;
      rsp_item_type           want;   // near_solid, flag_written, box_done
   } stim_row_type;

   localparam int DIRECTED_ROWS = 28;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // kind      index        value   voxel   typed  want
      '{ROW_CELL, 3'd0,        7'd0,   8'h00,  1'b1,  3'b000},  // origin after reset
      '{ROW_CELL, 3'd0,        7'd0,   8'hFF,  1'b1,  3'b000},  // low face, still stored
      '{ROW_CSR,  REG_X_START, 7'd1,   8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Y_START, 7'd1,   8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Z_START, 7'd1,   8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_X_END,   7'd3,   8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Y_END,   7'd3,   8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Z_END,   7'd3,   8'h00,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd91,  1'b1,  3'b110},  // sees (1,0,0) from the store
      '{ROW_CELL, 3'd0,        7'd0,   8'h01,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd6,   1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd20,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd37,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'h80,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd63,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'h7F,  1'b0,  3'b000},
      '{ROW_CSR,  REG_X_START, 7'h7F,  8'h00,  1'b0,  3'b000},  // upper bit dropped
      '{ROW_CSR,  REG_X_END,   7'd1,   8'h00,  1'b0,  3'b000},  // reversed axis
      '{ROW_CSR,  REG_Y_START, 7'd63,  8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Y_END,   7'd64,  8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Z_START, 7'd63,  8'h00,  1'b0,  3'b000},
      '{ROW_CSR,  REG_Z_END,   7'h7F,  8'h00,  1'b0,  3'b000},  // end past the volume
      '{ROW_CELL, 3'd0,        7'd0,   8'hFE,  1'b1,  3'b111},  // single voxel box at the far corner
      '{ROW_CELL, 3'd0,        7'd0,   8'h00,  1'b1,  3'b011},
      '{ROW_CSR,  REG_SPARE_A, 7'h55,  8'h00,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd86,  1'b1,  3'b011},
      '{ROW_CSR,  REG_SPARE_B, 7'h2A,  8'h00,  1'b0,  3'b000},
      '{ROW_CELL, 3'd0,        7'd0,   8'd200, 1'b1,  3'b111}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CELL_W-1:0]     req_cell_type = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_near_solid;
   logic                  rsp_flag_written;
   logic                  rsp_box_done;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   voxel_occupancy_dilation u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_type    (req_cell_type),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_near_solid   (rsp_near_solid),
      .rsp_flag_written (rsp_flag_written),
      .rsp_box_done     (rsp_box_done),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   bit                  occ_map [VOLUME_CELLS];
   logic [START_W-1:0]  box_lo [3];
   logic [END_W-1:0]    box_hi [3];
   int                  cursor [3];

   // expected result items in order, written at the tail and taken at the head
   rsp_item_type pending_flags [PEND_DEPTH];
   int  pend_head = 0;
   int  pend_tail = 0;
   int  mismatches = 0;
   int  cells_sent = 0;
   int  results_seen = 0;
   int  near_hits = 0;
   int  done_hits = 0;
   int  box_settings = 0;
   int  idle_cycles = 0;
   int  cycles_run = 0;
   int  hold_left = 0;
   bit  calm = 1'b0;

   function automatic int first_coord(input int a);
      int s;
      s = int'(box_lo[a]);
      return (s >= AXIS_SIZE[a]) ? AXIS_SIZE[a] - 1 : s;
   endfunction

   // one past the last coordinate of the axis
   function automatic int end_coord(input int a);
      int st;
      int en;
      st = first_coord(a);
      en = int'(box_hi[a]);
      if (en > AXIS_SIZE[a]) en = AXIS_SIZE[a];
      return (en <= st) ? st + 1 : en;
   endfunction

   function automatic int voxel_index(input int x, input int y, input int z);
      return x + y * SX + z * SX * SY;
   endfunction

   function automatic bit is_solid(input logic [CELL_W-1:0] voxel);
      bit solid;
      solid = (voxel != '0);
      for (int i = 0; i < PASS_COUNT; i++) begin
         if (voxel == PASS_TYPES[i]) solid = 1'b0;
      end
      return solid;
   endfunction

   function automatic void reload_cursor();
      for (int a = 0; a < 3; a++) cursor[a] = first_coord(a);
   endfunction

   function automatic void apply_config(input logic [CSR_IDX_W-1:0] index,
                                        input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_X_START: box_lo[0] = value[START_W-1:0];
         REG_Y_START: box_lo[1] = value[START_W-1:0];
         REG_Z_START: box_lo[2] = value[START_W-1:0];
         REG_X_END:   box_hi[0] = value[END_W-1:0];
         REG_Y_END:   box_hi[1] = value[END_W-1:0];
         REG_Z_END:   box_hi[2] = value[END_W-1:0];
         default: ;
      endcase
      reload_cursor();
   endfunction

   function automatic rsp_item_type predict_dilation(input logic [CELL_W-1:0] voxel);
      rsp_item_type r;
      int x;
      int y;
      int z;
      x = cursor[0];
      y = cursor[1];
      z = cursor[2];
      occ_map[voxel_index(x, y, z)] = is_solid(voxel);
      r = '0;
      if (x >= 1 && y >= 1 && z >= 1) begin
         r.flag_written = 1'b1;
         for (int dz = 0; dz < 2; dz++)
            for (int dy = 0; dy < 2; dy++)
               for (int dx = 0; dx < 2; dx++)
                  r.near_solid |= occ_map[voxel_index(x - dx, y - dy, z - dz)];
      end
      r.box_done = (x + 1 >= end_coord(0)) && (y + 1 >= end_coord(1)) &&
                   (z + 1 >= end_coord(2));
      // raster step, wrapping to the box start after the last voxel
      cursor[0]++;
      if (cursor[0] >= end_coord(0)) begin
         cursor[0] = first_coord(0);
         cursor[1]++;
         if (cursor[1] >= end_coord(1)) begin
            cursor[1] = first_coord(1);
            cursor[2]++;
            if (cursor[2] >= end_coord(2)) cursor[2] = first_coord(2);
         end
      end
      return r;
   endfunction

   function automatic int box_cells();
      int n;
      n = 1;
      for (int a = 0; a < 3; a++) n *= end_coord(a) - first_coord(a);
      return n;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CELL_W-1:0] pick_cell(input int solid_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < solid_pct) return CELL_W'($urandom_range(0, 255));
      if (roll < solid_pct + (100 - solid_pct) / 2) return '0;
      return PASS_TYPES[$urandom_range(0, PASS_COUNT - 1)];
   endfunction

   task automatic send_cell(input logic [CELL_W-1:0] voxel, input logic typed,
                            input rsp_item_type want);
      int gap;
      rsp_item_type predicted;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_type <= voxel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_dilation(voxel);
      pending_flags[pend_tail % PEND_DEPTH] = typed ? want : predicted;
      pend_tail++;
      cells_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_config(index, value);
   endtask

   // wait for every outstanding result, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pend_tail != pend_head) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_box();
      logic [CSR_DATA_W-1:0] lo [3];
      logic [CSR_DATA_W-1:0] hi [3];
      int mode;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (mode <= 6) begin
            // small boxes near the origin so passes overlap earlier ones
            lo[a] = CSR_DATA_W'($urandom_range(0, 6));
            hi[a] = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, lo[a]))
                                                 : CSR_DATA_W'(lo[a] + $urandom_range(1, 4));
         end else if (mode == 7) begin
            lo[a] = CSR_DATA_W'($urandom_range(60, 63));
            hi[a] = CSR_DATA_W'($urandom_range(61, 127));
         end else if (mode == 8 && a == 0) begin
            lo[a] = CSR_DATA_W'($urandom_range(0, 2));
            hi[a] = $urandom_range(0, 1) ? 7'd64 : 7'd127;
         end else if (mode == 8) begin
            lo[a] = CSR_DATA_W'($urandom_range(0, 3));
            hi[a] = CSR_DATA_W'(lo[a] + $urandom_range(1, 2));
         end else begin
            lo[a] = CSR_DATA_W'($urandom_range(0, 63));
            hi[a] = CSR_DATA_W'($urandom_range(0, 127));
         end
         if ($urandom_range(0, 3) == 0) lo[a] |= 7'h40;
      end
      if ($urandom_range(0, 4) == 0)
         write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                   CSR_DATA_W'($urandom_range(0, 127)));
      for (int a = 0; a < 3; a++) begin
         write_reg(START_REG[a], lo[a]);
         write_reg(END_REG[a], hi[a]);
      end
      csr_wen <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         hold_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen = '{rsp_near_solid, rsp_flag_written, rsp_box_done};
         results_seen++;
         near_hits += int'(seen.near_solid);
         done_hits += int'(seen.box_done);
         if (pend_tail == pend_head) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result item near=%b flag=%b done=%b",
                        $realtime, seen.near_solid, seen.flag_written, seen.box_done);
         end else begin
            want = pending_flags[pend_head % PEND_DEPTH];
            pend_head++;
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result %0d expected near=%b flag=%b done=%b, got %b %b %b",
                           $realtime, results_seen, want.near_solid, want.flag_written,
                           want.box_done, seen.near_solid, seen.flag_written, seen.box_done);
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either channel, and on the whole run
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run >= RUN_LIMIT) begin
         $display("timeout: run exceeded %0d cycles", RUN_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
      if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int burst;
      int solid_pct;
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = BOX_START_RESET;
         box_hi[a] = BOX_END_RESET;
      end
      reload_cursor();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            if (!csr_wen) settle();
            write_reg(DIRECTED[r].index, DIRECTED[r].value);
         end else begin
            if (csr_wen) csr_wen <= 1'b0;
            send_cell(DIRECTED[r].voxel, DIRECTED[r].typed, DIRECTED[r].want);
         end
      end

      while (cells_sent < TARGET_CELLS) begin
         settle();
         calm = ($urandom_range(0, 3) == 0);
         program_box();
         box_settings++;
         solid_pct = $urandom_range(3, 60);
         burst = $urandom_range(1, 2 * box_cells() + 3);
         if (burst > 120) burst = $urandom_range(40, 120);
         repeat (burst) send_cell(pick_cell(solid_pct), 1'b0, '0);
      end
      settle();

      $display("streamed %0d cells over %0d random box settings plus the directed rows",
               cells_sent, box_settings);
      $display("checked %0d results: near_solid high %0d times, box_done high %0d times",
               results_seen, near_hits, done_hits);
      if (mismatches == 0 && pend_tail == pend_head) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vod_pkg.sv
rtl/vod_ram.sv
rtl/voxel_occupancy_dilation.sv
dv/testbench.sv
